@@ hw/rtl/c2lla_pkg.sv @@
// Shared constants, types and the CORDIC angle table for the position converter.
package c2lla_pkg;

   localparam int POS_W           = 32;
   localparam int RADIUS_W        = 31;
   localparam int LON_W           = 29;
   localparam int LAT_W           = 28;
   localparam int ALT_W           = 34;
   localparam int ANGLE_FRAC_BITS = 20;
   localparam int ACC_FRAC        = 40;
   localparam int ACC_W           = 50;
   localparam int RND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int ANG_W           = ACC_W - RND_SHIFT;
   localparam int CORDIC_STEPS    = 48;
   localparam int ROOT_STEPS      = 32;
   localparam int NORM_TOP        = 59;
   localparam int ZV_EXP0         = 32;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd1632803;
   localparam logic [POS_W-1:0]    GAIN_LO      = 32'd2777814157;

   localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'd180 << ACC_FRAC);
   localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(64'd1 << (RND_SHIFT - 1));
   localparam logic signed [ANG_W-1:0] LON_FULL  = ANG_W'(64'd180 << ANGLE_FRAC_BITS);
   localparam logic signed [ANG_W-1:0] LAT_QUARTER = ANG_W'(64'd90 << ANGLE_FRAC_BITS);

   typedef enum logic [1:0] {
      BASE_NONE,
      BASE_POS,
      BASE_NEG
   } lon_base_type;

   typedef struct packed {
      logic             last;
      logic             z_neg;
      logic             z_zero;
      logic             xy_zero;
      logic [5:0]       eh;
      logic [5:0]       ez;
      logic [63:0]      zv;
      logic [LON_W-1:0] lon;
      logic [ALT_W-1:0] range_len;
   } side_type;

   typedef struct packed {
      logic [63:0]             x;
      logic [63:0]             y;
      logic signed [ACC_W-1:0] acc;
      side_type                side;
   } vec_type;

   typedef struct packed {
      logic [63:0] n;
      logic [63:0] res;
   } root_type;

   typedef logic [63:0] angle_tab_type [CORDIC_STEPS];

   function automatic logic [5:0] msb_pos(input logic [63:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         q = {q[62:0], 1'b0};
         if (r >= b) begin
            r = r - b;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] atan_pow2(input int i);
      logic [63:0] acc;
      logic        done;
      int          e;
      acc = '0;
      done = 1'b0;
      for (int k = 0; k < 64; k++) begin
         e = i * (2 * k + 1);
         if (e > 62) done = 1'b1;
         if (!done) begin
            if (k % 2 == 1) acc = acc - udiv(64'd1 << (62 - e), 64'(2 * k + 1));
            else acc = acc + udiv(64'd1 << (62 - e), 64'(2 * k + 1));
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] atan_third();
      logic [63:0] p;
      logic [63:0] acc;
      p = udiv(64'd1 << 62, 64'd3);
      acc = '0;
      for (int k = 0; k < 40; k++) begin
         if (p != 0) begin
            if (k % 2 == 1) acc = acc - udiv(p, 64'(2 * k + 1));
            else acc = acc + udiv(p, 64'(2 * k + 1));
            p = udiv(p, 64'd9);
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] frac_div(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = a;
      if (r >= b) begin
         q = 64'd1;
         r = r - b;
      end
      for (int n = 0; n < 56; n++) begin
         r = {r[62:0], 1'b0};
         q = {q[62:0], 1'b0};
         if (r >= b) begin
            r = r - b;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic angle_tab_type build_angle_tab();
      angle_tab_type tab;
      logic [63:0]   quarter;
      logic [63:0]   a;
      logic [63:0]   q;
      quarter = atan_pow2(1) + atan_third();
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         a = (i == 0) ? quarter : atan_pow2(i);
         q = frac_div(a, quarter);
         tab[i] = (q * 64'd45 + (64'd1 << 15)) >> 16;
      end
      return tab;
   endfunction

   localparam angle_tab_type ANGLE_TAB = build_angle_tab();

endpackage

@@ hw/rtl/c2lla_front.sv @@
// Input stages: magnitudes, half-plane fold, scaling, squares and the z gain product.
module c2lla_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic signed [c2lla_pkg::POS_W-1:0] pos_x,
   input  logic signed [c2lla_pkg::POS_W-1:0] pos_y,
   input  logic signed [c2lla_pkg::POS_W-1:0] pos_z,
   input  logic                               last_in,
   output logic                               out_valid,
   output c2lla_pkg::vec_type                 out_vec,
   output c2lla_pkg::root_type                out_root
);
   import c2lla_pkg::*;

   logic               p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic [POS_W-1:0]   p1_ax_ff, p1_ay_ff, p1_az_ff, p1_m_ff;
   logic [POS_W:0]     p1_yf_ff;
   lon_base_type       p1_base_ff;
   logic               p1_last_ff, p1_zneg_ff, p1_zzero_ff;
   logic [POS_W-1:0]   p1_ax_in, p1_ay_in, p1_az_in, p1_m_in;
   logic [POS_W:0]     p1_yf_in;
   lon_base_type       p1_base_in;

   logic [63:0]        p2_xs_ff, p2_ys_ff, p2_sqx_ff, p2_sqy_ff, p2_sqz_ff, p2_zlo_ff;
   logic [POS_W-1:0]   p2_az_ff;
   logic [5:0]         p2_eh_ff;
   logic               p2_xyzero_ff, p2_last_ff, p2_zneg_ff, p2_zzero_ff;
   lon_base_type       p2_base_ff;
   logic [5:0]         p2_eh_in;
   logic [63:0]        p2_xs_in, p2_ys_in;

   logic [63:0]        p3_xs_ff, p3_ys_ff, p3_n_ff, p3_zv_ff;
   logic [5:0]         p3_eh_ff;
   logic               p3_xyzero_ff, p3_last_ff, p3_zneg_ff, p3_zzero_ff;
   lon_base_type       p3_base_ff;

   vec_type            p4_vec_ff, p4_vec_in;
   root_type           p4_root_ff;
   logic [5:0]         p4_pz;
   logic [6:0]         p4_ez;

   always_comb begin
      p1_ax_in = pos_x[POS_W-1] ? (~pos_x + 1'b1) : pos_x;
      p1_ay_in = pos_y[POS_W-1] ? (~pos_y + 1'b1) : pos_y;
      p1_az_in = pos_z[POS_W-1] ? (~pos_z + 1'b1) : pos_z;
      p1_m_in  = (p1_ax_in > p1_ay_in) ? p1_ax_in : p1_ay_in;
      p1_yf_in = pos_x[POS_W-1] ? (~{pos_y[POS_W-1], pos_y} + 1'b1) : {pos_y[POS_W-1], pos_y};
      if (!pos_x[POS_W-1]) p1_base_in = BASE_NONE;
      else if (pos_y[POS_W-1]) p1_base_in = BASE_NEG;
      else p1_base_in = BASE_POS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ax_ff    <= p1_ax_in;
         p1_ay_ff    <= p1_ay_in;
         p1_az_ff    <= p1_az_in;
         p1_m_ff     <= p1_m_in;
         p1_yf_ff    <= p1_yf_in;
         p1_base_ff  <= p1_base_in;
         p1_last_ff  <= last_in;
         p1_zneg_ff  <= pos_z[POS_W-1];
         p1_zzero_ff <= (pos_z == '0);
      end
   end

   always_comb begin
      p2_eh_in = 6'(NORM_TOP) - msb_pos(64'(p1_m_ff));
      p2_xs_in = 64'(p1_ax_ff) << p2_eh_in;
      p2_ys_in = {{(64-POS_W-1){p1_yf_ff[POS_W]}}, p1_yf_ff} << p2_eh_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_xs_ff     <= p2_xs_in;
         p2_ys_ff     <= p2_ys_in;
         p2_eh_ff     <= p2_eh_in;
         p2_xyzero_ff <= (p1_m_ff == '0);
         p2_sqx_ff    <= 64'(p1_ax_ff) * 64'(p1_ax_ff);
         p2_sqy_ff    <= 64'(p1_ay_ff) * 64'(p1_ay_ff);
         p2_sqz_ff    <= 64'(p1_az_ff) * 64'(p1_az_ff);
         p2_zlo_ff    <= 64'(p1_az_ff) * 64'(GAIN_LO);
         p2_az_ff     <= p1_az_ff;
         p2_base_ff   <= p1_base_ff;
         p2_last_ff   <= p1_last_ff;
         p2_zneg_ff   <= p1_zneg_ff;
         p2_zzero_ff  <= p1_zzero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_xs_ff     <= p2_xs_ff;
         p3_ys_ff     <= p2_ys_ff;
         p3_eh_ff     <= p2_eh_ff;
         p3_xyzero_ff <= p2_xyzero_ff;
         p3_n_ff      <= p2_sqx_ff + p2_sqy_ff + p2_sqz_ff;
         p3_zv_ff     <= p2_zlo_ff + {p2_az_ff, 32'd0};
         p3_base_ff   <= p2_base_ff;
         p3_last_ff   <= p2_last_ff;
         p3_zneg_ff   <= p2_zneg_ff;
         p3_zzero_ff  <= p2_zzero_ff;
      end
   end

   always_comb begin
      p4_pz = msb_pos(p3_zv_ff);
      p4_ez = 7'(ZV_EXP0 + NORM_TOP) - {1'b0, p4_pz};
      p4_vec_in = '0;
      p4_vec_in.x = p3_xs_ff;
      p4_vec_in.y = p3_ys_ff;
      case (p3_base_ff)
         BASE_POS: p4_vec_in.acc = HALF_TURN;
         BASE_NEG: p4_vec_in.acc = -HALF_TURN;
         default:  p4_vec_in.acc = '0;
      endcase
      p4_vec_in.side.last    = p3_last_ff;
      p4_vec_in.side.z_neg   = p3_zneg_ff;
      p4_vec_in.side.z_zero  = p3_zzero_ff;
      p4_vec_in.side.xy_zero = p3_xyzero_ff;
      p4_vec_in.side.eh      = p3_eh_ff;
      p4_vec_in.side.ez      = p4_ez[5:0];
      if (p4_pz >= 6'(NORM_TOP)) begin
         p4_vec_in.side.zv = p3_zv_ff >> (p4_pz - 6'(NORM_TOP));
      end else begin
         p4_vec_in.side.zv = p3_zv_ff << (6'(NORM_TOP) - p4_pz);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_vec_ff      <= p4_vec_in;
         p4_root_ff.n   <= p3_n_ff;
         p4_root_ff.res <= '0;
      end
   end

   assign out_valid = p4_valid_ff;
   assign out_vec   = p4_vec_ff;
   assign out_root  = p4_root_ff;

endmodule

@@ hw/rtl/c2lla_vector_chain.sv @@
// Pipelined CORDIC vectoring chain, one micro-rotation per register stage.
module c2lla_vector_chain (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  c2lla_pkg::vec_type in_data,
   output logic               out_valid,
   output c2lla_pkg::vec_type out_data
);
   import c2lla_pkg::*;

   logic    valid_ff [CORDIC_STEPS];
   vec_type data_ff  [CORDIC_STEPS];
   vec_type data_in  [CORDIC_STEPS];
   logic    src_valid [CORDIC_STEPS];
   vec_type src_data [CORDIC_STEPS];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
      if (g == 0) begin : g_head
         assign src_valid[g] = in_valid;
         assign src_data[g]  = in_data;
      end else begin : g_body
         assign src_valid[g] = valid_ff[g-1];
         assign src_data[g]  = data_ff[g-1];
      end

      always_comb begin
         logic [63:0] dx;
         logic [63:0] dy;
         dx = 64'($signed(src_data[g].y) >>> g);
         dy = 64'($signed(src_data[g].x) >>> g);
         data_in[g] = src_data[g];
         if (src_data[g].y[63]) begin
            data_in[g].x   = src_data[g].x - dx;
            data_in[g].y   = src_data[g].y + dy;
            data_in[g].acc = src_data[g].acc - ACC_W'(ANGLE_TAB[g]);
         end else begin
            data_in[g].x   = src_data[g].x + dx;
            data_in[g].y   = src_data[g].y - dy;
            data_in[g].acc = src_data[g].acc + ACC_W'(ANGLE_TAB[g]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= src_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) data_ff[g] <= data_in[g];
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS-1];
   assign out_data  = data_ff[CORDIC_STEPS-1];

endmodule

@@ hw/rtl/c2lla_root.sv @@
// Pipelined integer square root, one result bit per stage, padded to the CORDIC depth.
module c2lla_root (
   input  logic                clock,
   input  logic                en,
   input  c2lla_pkg::root_type in_data,
   output c2lla_pkg::root_type out_data
);
   import c2lla_pkg::*;

   root_type data_ff  [CORDIC_STEPS];
   root_type data_in  [CORDIC_STEPS];
   root_type src_data [CORDIC_STEPS];

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
      if (g == 0) begin : g_head
         assign src_data[g] = in_data;
      end else begin : g_body
         assign src_data[g] = data_ff[g-1];
      end

      if (g < ROOT_STEPS) begin : g_digit
         always_comb begin
            logic [63:0] bit_val;
            logic [63:0] trial;
            bit_val = 64'd1 << (62 - 2 * g);
            trial = src_data[g].res + bit_val;
            if (src_data[g].n >= trial) begin
               data_in[g].n   = src_data[g].n - trial;
               data_in[g].res = (src_data[g].res >> 1) + bit_val;
            end else begin
               data_in[g].n   = src_data[g].n;
               data_in[g].res = src_data[g].res >> 1;
            end
         end
      end else begin : g_pass
         assign data_in[g] = src_data[g];
      end

      always_ff @(posedge clock) begin
         if (en) data_ff[g] <= data_in[g];
      end
   end

   assign out_data = data_ff[CORDIC_STEPS-1];

endmodule

@@ hw/rtl/c2lla_mid.sv @@
// Longitude rounding, range rounding and alignment of the latitude chain operands.
module c2lla_mid (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  c2lla_pkg::vec_type  in_vec,
   input  c2lla_pkg::root_type in_root,
   output logic                out_valid,
   output c2lla_pkg::vec_type  out_vec
);
   import c2lla_pkg::*;

   logic               m1_valid_ff, m2_valid_ff;
   logic [63:0]        m1_hn_ff;
   logic signed [6:0]  m1_d_ff;
   side_type           m1_side_ff;
   vec_type            m2_vec_ff;

   logic [63:0]             m1_hn_in;
   logic signed [6:0]       m1_d_in;
   side_type                m1_side_in;
   logic [1:0]              m1_sh;
   logic [5:0]              m1_eh;
   logic signed [ACC_W-1:0] m1_t;
   logic signed [ANG_W-1:0] m1_lon;
   vec_type                 m2_vec_in;
   logic [6:0]              m2_nd;

   always_comb begin
      m1_t = in_vec.acc + RND_HALF;
      m1_lon = m1_t[ACC_W-1:RND_SHIFT];
      if (m1_lon == -LON_FULL) m1_lon = LON_FULL;
      if (in_vec.side.xy_zero) m1_lon = '0;

      if (in_vec.x[61]) m1_sh = 2'd2;
      else if (in_vec.x[60]) m1_sh = 2'd1;
      else m1_sh = 2'd0;
      m1_hn_in = in_vec.x >> m1_sh;
      m1_eh = in_vec.side.eh - 6'(m1_sh);
      m1_d_in = $signed({1'b0, m1_eh}) - $signed({1'b0, in_vec.side.ez});

      m1_side_in = in_vec.side;
      m1_side_in.lon = m1_lon[LON_W-1:0];
      m1_side_in.range_len = ALT_W'(in_root.res) + ALT_W'(in_root.n > in_root.res);
   end

   always_comb begin
      m2_nd = 7'(-m1_d_ff);
      m2_vec_in = '0;
      m2_vec_in.side = m1_side_ff;
      if (m1_d_ff > 0) begin
         m2_vec_in.x = m1_hn_ff >> m1_d_ff[5:0];
         m2_vec_in.y = m1_side_ff.zv;
      end else begin
         m2_vec_in.x = m1_hn_ff;
         m2_vec_in.y = m1_side_ff.zv >> m2_nd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_hn_ff   <= m1_hn_in;
         m1_d_ff    <= m1_d_in;
         m1_side_ff <= m1_side_in;
         m2_vec_ff  <= m2_vec_in;
      end
   end

   assign out_valid = m2_valid_ff;
   assign out_vec   = m2_vec_ff;

endmodule

@@ hw/rtl/cartesian_to_lat_lon_alt.sv @@
// Top level of the Earth-centered position to longitude, latitude and altitude converter.
//
// A position beat (req_pos_x, req_pos_y, req_pos_z, req_last_in) is taken at a rising
// clock edge with req_valid high and req_stall low. Each position gives one result beat
// (rsp_longitude, rsp_latitude, rsp_altitude, rsp_last_out) in the same order, taken at
// an edge with rsp_valid high and rsp_stall low.
// The result passes through four input stages, a 48-stage longitude CORDIC chain with the
// square root beside it, two alignment stages, a 48-stage latitude CORDIC chain and the
// output register. One position is taken every cycle while req_stall is low.
// The sphere radius resets to 6378.135 km and is written through csr_write_en and
// csr_write_data; the user must do so only while the block is idle (not enforced).
// When the receiver stalls, the result waits in the output register and one more beat
// lands in a skid register; only then does req_stall rise and the whole pipeline hold.
// Reset empties the pipeline and restores the radius.
module cartesian_to_lat_lon_alt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [c2lla_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [c2lla_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [c2lla_pkg::POS_W-1:0]    req_pos_z,
   input  logic                                  req_last_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [c2lla_pkg::LON_W-1:0]    rsp_longitude,
   output logic signed [c2lla_pkg::LAT_W-1:0]    rsp_latitude,
   output logic signed [c2lla_pkg::ALT_W-1:0]    rsp_altitude,
   output logic                                  rsp_last_out,
   input  logic                                  csr_write_en,
   input  logic [c2lla_pkg::RADIUS_W-1:0]        csr_write_data
);
   import c2lla_pkg::*;

   logic                en;
   logic                front_valid, lon_valid, mid_valid, lat_valid;
   vec_type             front_vec, lon_vec, mid_vec, lat_vec;
   root_type            front_root, root_out;

   logic [RADIUS_W-1:0] radius_ff;
   logic                rsp_valid_ff, skid_full_ff;
   logic [LON_W-1:0]    rsp_lon_ff, skid_lon_ff;
   logic [LAT_W-1:0]    rsp_lat_ff, skid_lat_ff;
   logic [ALT_W-1:0]    rsp_alt_ff, skid_alt_ff;
   logic                rsp_last_ff, skid_last_ff;

   logic signed [ACC_W-1:0] o_t;
   logic signed [ANG_W-1:0] o_lat;
   logic [LAT_W-1:0]        o_lat_in;
   logic [ALT_W-1:0]        o_alt_in;
   logic                    take;

   assign en = !skid_full_ff;
   assign req_stall = skid_full_ff;

   c2lla_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .last_in   (req_last_in),
      .out_valid (front_valid),
      .out_vec   (front_vec),
      .out_root  (front_root)
   );

   c2lla_vector_chain u_lon_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_vec),
      .out_valid (lon_valid),
      .out_data  (lon_vec)
   );

   c2lla_root u_root (
      .clock    (clock),
      .en       (en),
      .in_data  (front_root),
      .out_data (root_out)
   );

   c2lla_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (lon_valid),
      .in_vec    (lon_vec),
      .in_root   (root_out),
      .out_valid (mid_valid),
      .out_vec   (mid_vec)
   );

   c2lla_vector_chain u_lat_chain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mid_valid),
      .in_data   (mid_vec),
      .out_valid (lat_valid),
      .out_data  (lat_vec)
   );

   always_comb begin
      o_t = lat_vec.acc + RND_HALF;
      o_lat = o_t[ACC_W-1:RND_SHIFT];
      if (o_lat < 0) o_lat = '0;
      if (o_lat > LAT_QUARTER) o_lat = LAT_QUARTER;
      if (lat_vec.side.xy_zero) o_lat = LAT_QUARTER;
      if (lat_vec.side.z_zero) o_lat = '0;
      if (lat_vec.side.z_neg) o_lat = -o_lat;
      o_lat_in = o_lat[LAT_W-1:0];
      o_alt_in = lat_vec.side.range_len - ALT_W'(radius_ff);
   end

   assign take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_write_en) begin
         radius_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (take) skid_full_ff <= 1'b0;
      end else if (rsp_valid_ff && !take) begin
         if (lat_valid) skid_full_ff <= 1'b1;
      end else begin
         rsp_valid_ff <= lat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (take) begin
            rsp_lon_ff  <= skid_lon_ff;
            rsp_lat_ff  <= skid_lat_ff;
            rsp_alt_ff  <= skid_alt_ff;
            rsp_last_ff <= skid_last_ff;
         end
      end else if (rsp_valid_ff && !take) begin
         skid_lon_ff  <= lat_vec.side.lon;
         skid_lat_ff  <= o_lat_in;
         skid_alt_ff  <= o_alt_in;
         skid_last_ff <= lat_vec.side.last;
      end else begin
         rsp_lon_ff  <= lat_vec.side.lon;
         rsp_lat_ff  <= o_lat_in;
         rsp_alt_ff  <= o_alt_in;
         rsp_last_ff <= lat_vec.side.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_longitude = rsp_lon_ff;
   assign rsp_latitude  = rsp_lat_ff;
   assign rsp_altitude  = rsp_alt_ff;
   assign rsp_last_out  = rsp_last_ff;

endmodule

@@ bench/tb_cartesian_to_lat_lon_alt.sv @@
// Self-checking testbench for the Earth-centered position to longitude, latitude, altitude converter.
module tb_cartesian_to_lat_lon_alt;
   timeunit 1ns;
   timeprecision 1ps;
   import c2lla_pkg::*;

   localparam int LATENCY = 102;
   localparam longint MAX_CYCLES = 400000;
   localparam logic [63:0] GAIN_Q32 = 64'd7072781453;

   typedef struct packed {
      logic [LON_W-1:0] lon;
      logic [LAT_W-1:0] lat;
      logic [ALT_W-1:0] alt;
      logic             last;
   } geo_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic req_last_in = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [LON_W-1:0] rsp_longitude;
   logic signed [LAT_W-1:0] rsp_latitude;
   logic signed [ALT_W-1:0] rsp_altitude;
   logic rsp_last_out;
   logic csr_write_en = 1'b0;
   logic [RADIUS_W-1:0] csr_write_data = '0;

   logic [63:0] atan_deg [CORDIC_STEPS];
   logic [63:0] radius_model;
   geo_type pending_geo [$];
   int errors = 0;
   longint cycles = 0;
   bit calm = 1'b0;

   cartesian_to_lat_lon_alt dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [63:0] asr(input logic [63:0] v, input int s);
      if (s > 63) s = 63;
      return 64'($signed(v) >>> s);
   endfunction

   function automatic logic [63:0] atan_series(input int i);
      logic [63:0] acc;
      int e;
      acc = 0;
      for (int k = 0; k < 64; k++) begin
         e = i * (2 * k + 1);
         if (e > 62) break;
         if (k % 2) acc -= (64'd1 << (62 - e)) / (2 * k + 1);
         else acc += (64'd1 << (62 - e)) / (2 * k + 1);
      end
      return acc;
   endfunction

   function automatic void fill_atan_deg();
      logic [63:0] p, acc, quarter, a, q, r;
      int k;
      p = (64'd1 << 62) / 3;
      acc = 0;
      k = 0;
      while (p != 0) begin
         if (k % 2) acc -= p / (2 * k + 1);
         else acc += p / (2 * k + 1);
         p /= 9;
         k++;
      end
      quarter = atan_series(1) + acc;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         a = (i == 0) ? quarter : atan_series(i);
         q = 0;
         r = a;
         if (r >= quarter) begin
            q = 1;
            r -= quarter;
         end
         for (int n = 0; n < 56; n++) begin
            r <<= 1;
            q <<= 1;
            if (r >= quarter) begin
               r -= quarter;
               q |= 1;
            end
         end
         atan_deg[i] = (q * 45 + (64'd1 << 15)) >> 16;
      end
   endfunction

   function automatic logic [63:0] vector_angle(input logic [63:0] x0, input logic [63:0] y0,
                                                output logic [63:0] mag);
      logic [63:0] x, y, acc, dx, dy;
      x = x0;
      y = y0;
      acc = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = asr(y, i);
         dy = asr(x, i);
         if (y[63]) begin
            x -= dx;
            y += dy;
            acc -= atan_deg[i];
         end else begin
            x += dx;
            y -= dy;
            acc += atan_deg[i];
         end
      end
      mag = x;
      return acc;
   endfunction

   function automatic logic [63:0] round_deg(input logic [63:0] acc);
      return asr(acc + (64'd1 << (RND_SHIFT - 1)), RND_SHIFT);
   endfunction

   function automatic void norm60(inout logic [63:0] v, inout int e);
      while (v >= (64'd1 << 60)) begin
         v >>= 1;
         e--;
      end
      while (v < (64'd1 << 59)) begin
         v <<= 1;
         e++;
      end
   endfunction

   function automatic logic [63:0] root_nearest(input logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return (n > res) ? res + 1 : res;
   endfunction

   function automatic geo_type convert_position(input logic signed [31:0] px,
                                                input logic signed [31:0] py,
                                                input logic signed [31:0] pz,
                                                input logic lst);
      logic [63:0] x, y, ax, ay, az, lon, lat, hmag, m, base, zv, dmy, r, rng;
      logic [63:0] full, quarter;
      int eh, ez, d;
      geo_type g;
      x = 64'(px);
      y = 64'(py);
      ax = x[63] ? -x : x;
      ay = y[63] ? -y : y;
      az = pz < 0 ? 64'(-64'(pz)) : 64'(pz);
      full = 64'd180 << ANGLE_FRAC_BITS;
      quarter = 64'd90 << ANGLE_FRAC_BITS;
      lon = 0;
      lat = 0;
      hmag = 0;
      eh = 0;
      if (ax != 0 || ay != 0) begin
         base = 0;
         if (x[63]) begin
            base = y[63] ? -(64'd180 << ACC_FRAC) : (64'd180 << ACC_FRAC);
            x = -x;
            y = -y;
         end
         m = ax > ay ? ax : ay;
         while (m < (64'd1 << 59)) begin
            m <<= 1;
            x <<= 1;
            y <<= 1;
            eh++;
         end
         lon = round_deg(base + vector_angle(x, y, hmag));
         if (lon == -full) lon = full;
      end
      if (az != 0) begin
         if (hmag == 0) lat = quarter;
         else begin
            zv = az * GAIN_Q32;
            ez = 32;
            norm60(hmag, eh);
            norm60(zv, ez);
            d = eh - ez;
            if (d > 0) hmag = d > 63 ? 0 : hmag >> d;
            else if (d < 0) zv = -d > 63 ? 0 : zv >> (-d);
            r = round_deg(vector_angle(hmag, zv, dmy));
            if (r[63]) r = 0;
            if (r > quarter) r = quarter;
            lat = r;
         end
         if (pz < 0) lat = -lat;
      end
      rng = root_nearest(ax * ax + ay * ay + az * az);
      g.lon = lon[LON_W-1:0];
      g.lat = lat[LAT_W-1:0];
      g.alt = ALT_W'(rng - radius_model);
      g.last = lst;
      return g;
   endfunction

   always @(posedge clock) begin
      geo_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_geo.size() == 0) begin
            $error("result beat with no position pending");
            errors++;
         end else begin
            want = pending_geo.pop_front();
            if (rsp_longitude !== want.lon) begin
               $error("longitude: expected %0d, got %0d", $signed(want.lon), rsp_longitude);
               errors++;
            end
            if (rsp_latitude !== want.lat) begin
               $error("latitude: expected %0d, got %0d", $signed(want.lat), rsp_latitude);
               errors++;
            end
            if (rsp_altitude !== want.alt) begin
               $error("altitude: expected %0d, got %0d", $signed(want.alt), rsp_altitude);
               errors++;
            end
            if (rsp_last_out !== want.last) begin
               $error("last_out: expected %0b, got %0b", want.last, rsp_last_out);
               errors++;
            end
         end
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   task automatic send_position(input logic signed [31:0] px, input logic signed [31:0] py,
                                input logic signed [31:0] pz, input logic lst);
      int n;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 8);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_last_in <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_geo.push_back(convert_position(px, py, pz, lst));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_geo.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_radius(input logic [RADIUS_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      radius_model = 64'(value);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         1: return 32'($signed($urandom_range(0, 8)) - 4);
         2: return $urandom_range(1400000, 1800000) * ($urandom_range(0, 1) ? -1 : 1);
         3: return 32'($signed($urandom_range(0, 4000)) - 2000);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed_positions();
      logic signed [31:0] big, low;
      big = 32'h7FFFFFFF;
      low = 32'h80000000;
      send_position(0, 0, 0, 1'b0);
      send_position(0, 0, 1632803, 1'b1);
      send_position(0, 0, -1632803, 1'b0);
      send_position(1632803, 0, 0, 1'b0);
      send_position(-1632803, 0, 0, 1'b0);
      send_position(-1632803, -1, 0, 1'b1);
      send_position(0, 1632803, 0, 1'b0);
      send_position(0, -1632803, 0, 1'b0);
      send_position(big, big, big, 1'b0);
      send_position(low, low, low, 1'b1);
      send_position(low, 0, 0, 1'b0);
      send_position(low, -1, 5, 1'b0);
      send_position(1, 0, big, 1'b0);
      send_position(1, 1, low, 1'b0);
      send_position(big, low, 1, 1'b0);
      send_position(-1, 1, -1, 1'b1);
      send_position(1000000, 1000000, 1000000, 1'b0);
      send_position(-1000000, -1000000, 0, 1'b0);
   endtask

   task automatic test_radius_settings();
      logic [RADIUS_W-1:0] setting [4];
      setting = '{31'd0, 31'h7FFFFFFF, 31'd1, 31'd1632803};
      foreach (setting[i]) begin
         drain_results();
         write_radius(setting[i]);
         for (int k = 0; k < 20; k++)
            send_position(random_coord(), random_coord(), random_coord(),
                          1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_positions();
      for (int k = 0; k < 1100; k++) begin
         if (k == 500) begin
            drain_results();
            write_radius(RADIUS_W'($urandom_range(1500000, 1700000)));
         end
         if (k == 900) calm = 1'b1;
         send_position(random_coord(), random_coord(), random_coord(),
                       1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      fill_atan_deg();
      radius_model = 64'(RADIUS_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_positions();
      test_radius_settings();
      test_random_positions();
      drain_results();
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/c2lla_pkg.sv
hw/rtl/c2lla_front.sv
hw/rtl/c2lla_vector_chain.sv
hw/rtl/c2lla_root.sv
hw/rtl/c2lla_mid.sv
hw/rtl/cartesian_to_lat_lon_alt.sv
bench/tb_cartesian_to_lat_lon_alt.sv
